[rtl/core/rsmc_pkg.sv]
// ============================================================================
// rsmc_pkg - shared types, constants and microcode for the symbol cipher
// Holds the control word layout, the status flags and the program ROM.
// ============================================================================
package rsmc_pkg;

  // Default width of the modulus and exponent registers.
  localparam int MOD_WIDTH_DEF = 31;

  // Width of the wrapped difference that is reduced modulo the modulus.
  localparam int DIFF_W = 64;

  // Offset subtracted from the symbol and added back to the power.
  localparam int SYMBOL_OFFSET = 96;

  // Register reset values.
  localparam int MODULUS_RST     = 77;
  localparam int PUB_EXP_RST     = 7;
  localparam int PRIV_EXP_RST    = 43;

  // Configuration register indexes.
  localparam logic [1:0] REG_MODULUS  = 2'd0;
  localparam logic [1:0] REG_PUB_EXP  = 2'd1;
  localparam logic [1:0] REG_PRIV_EXP = 2'd2;

  typedef logic [3:0] pc_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_RED,       // one bit of the restoring reduction
    OP_PINIT,     // base = remainder, result = 1, load exponent
    OP_SET_RB,    // start result * base
    OP_SET_BB,    // start base * base
    OP_MSTEP,     // one shift-and-add step of the modular product
    OP_WR_RES,    // result = product
    OP_WR_BASE,   // base = product, exponent shifts right
    OP_EMIT       // load the output register
  } op_t;

  typedef enum logic [3:0] {
    C_NONE,
    C_ALWAYS,
    C_NO_INPUT,
    C_CNT_MORE,
    C_EXP_ZERO,
    C_EXP_EVEN,
    C_B_MORE,
    C_EXP_MORE,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } ctrl_t;

  typedef struct packed {
    logic cnt_last;
    logic exp_zero;
    logic exp_even;
    logic b_more;
    logic exp_more;
  } stat_t;

  // Program addresses.
  localparam pc_t PC_WAIT   = 4'd0;
  localparam pc_t PC_RED    = 4'd1;
  localparam pc_t PC_PINIT  = 4'd2;
  localparam pc_t PC_TEST   = 4'd3;
  localparam pc_t PC_SETRB  = 4'd4;
  localparam pc_t PC_MULRB  = 4'd5;
  localparam pc_t PC_WRRES  = 4'd6;
  localparam pc_t PC_SETBB  = 4'd7;
  localparam pc_t PC_MULBB  = 4'd8;
  localparam pc_t PC_WRBASE = 4'd9;
  localparam pc_t PC_EMIT   = 4'd10;
  localparam pc_t PC_RET    = 4'd11;
  localparam pc_t PC_LAST   = PC_RET;

  // Program ROM: a jump is taken to target when the condition holds,
  // otherwise the step counter advances by one.
  function automatic ctrl_t ucode(pc_t pc);
    ctrl_t w;
    w = '{op: OP_NOP, cond: C_ALWAYS, target: PC_WAIT};
    case (pc)
      PC_WAIT:   w = '{op: OP_NOP,     cond: C_NO_INPUT, target: PC_WAIT};
      PC_RED:    w = '{op: OP_RED,     cond: C_CNT_MORE, target: PC_RED};
      PC_PINIT:  w = '{op: OP_PINIT,   cond: C_EXP_ZERO, target: PC_EMIT};
      PC_TEST:   w = '{op: OP_NOP,     cond: C_EXP_EVEN, target: PC_SETBB};
      PC_SETRB:  w = '{op: OP_SET_RB,  cond: C_NONE,     target: PC_WAIT};
      PC_MULRB:  w = '{op: OP_MSTEP,   cond: C_B_MORE,   target: PC_MULRB};
      PC_WRRES:  w = '{op: OP_WR_RES,  cond: C_NONE,     target: PC_WAIT};
      PC_SETBB:  w = '{op: OP_SET_BB,  cond: C_NONE,     target: PC_WAIT};
      PC_MULBB:  w = '{op: OP_MSTEP,   cond: C_B_MORE,   target: PC_MULBB};
      PC_WRBASE: w = '{op: OP_WR_BASE, cond: C_EXP_MORE, target: PC_TEST};
      PC_EMIT:   w = '{op: OP_EMIT,    cond: C_OUT_BUSY, target: PC_EMIT};
      PC_RET:    w = '{op: OP_NOP,     cond: C_ALWAYS,   target: PC_WAIT};
      default:   w = '{op: OP_NOP,     cond: C_ALWAYS,   target: PC_WAIT};
    endcase
    return w;
  endfunction

endpackage

[rtl/core/rsmc_datapath.sv]
// ============================================================================
// rsmc_datapath - reduction and modular multiply datapath
// Registers and adders driven one control word per cycle by the sequencer.
// ============================================================================
module rsmc_datapath #(
  parameter int MOD_WIDTH = rsmc_pkg::MOD_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 load,
  input  logic                 load_func,
  input  logic [31:0]          load_symbol,
  input  rsmc_pkg::ctrl_t      ctrl,
  input  logic [MOD_WIDTH-1:0] modulus,
  input  logic [MOD_WIDTH-1:0] public_exponent,
  input  logic [MOD_WIDTH-1:0] private_exponent,
  output rsmc_pkg::stat_t      stat,
  output logic [MOD_WIDTH-1:0] power
);

  localparam int CNT_W = $clog2(rsmc_pkg::DIFF_W) + 1;

  logic                         func_q;
  logic [rsmc_pkg::DIFF_W-1:0]  dreg;
  logic [CNT_W-1:0]             cnt;
  logic [MOD_WIDTH-1:0]         rem;
  logic [MOD_WIDTH-1:0]         base;
  logic [MOD_WIDTH-1:0]         result;
  logic [MOD_WIDTH-1:0]         acc;
  logic [MOD_WIDTH-1:0]         a;
  logic [MOD_WIDTH-1:0]         b;
  logic [MOD_WIDTH-1:0]         exp;
  logic [MOD_WIDTH-1:0]         exp_sel;

  logic [MOD_WIDTH:0]   mod_ext;
  logic [MOD_WIDTH:0]   trial;
  logic [MOD_WIDTH:0]   sum_acc;
  logic [MOD_WIDTH:0]   sum_dbl;
  logic [MOD_WIDTH-1:0] rem_next;
  logic [MOD_WIDTH-1:0] acc_next;
  logic [MOD_WIDTH-1:0] a_next;

  // Exponent picked by the captured selector.
  assign exp_sel = func_q ? private_exponent : public_exponent;

  // Each add is followed by a single conditional subtract, since both
  // operands stay below the modulus.
  always_comb begin
    mod_ext  = {1'b0, modulus};
    trial    = {rem, dreg[rsmc_pkg::DIFF_W-1]};
    sum_acc  = {1'b0, acc} + {1'b0, a};
    sum_dbl  = {1'b0, a} + {1'b0, a};
    rem_next = (trial >= mod_ext) ? MOD_WIDTH'(trial - mod_ext) : MOD_WIDTH'(trial);
    acc_next = (sum_acc >= mod_ext) ? MOD_WIDTH'(sum_acc - mod_ext) : MOD_WIDTH'(sum_acc);
    a_next   = (sum_dbl >= mod_ext) ? MOD_WIDTH'(sum_dbl - mod_ext) : MOD_WIDTH'(sum_dbl);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      func_q <= load_func;
      dreg   <= {{(rsmc_pkg::DIFF_W-32){1'b0}}, load_symbol}
                - rsmc_pkg::DIFF_W'(rsmc_pkg::SYMBOL_OFFSET);
      cnt    <= CNT_W'(rsmc_pkg::DIFF_W);
      rem    <= '0;
    end
    case (ctrl.op)
      rsmc_pkg::OP_RED: begin
        rem  <= rem_next;
        dreg <= {dreg[rsmc_pkg::DIFF_W-2:0], 1'b0};
        cnt  <= cnt - CNT_W'(1);
      end
      rsmc_pkg::OP_PINIT: begin
        base   <= rem;
        result <= MOD_WIDTH'(1);
        exp    <= exp_sel;
      end
      rsmc_pkg::OP_SET_RB: begin
        acc <= '0;
        a   <= result;
        b   <= base;
      end
      rsmc_pkg::OP_SET_BB: begin
        acc <= '0;
        a   <= base;
        b   <= base;
      end
      rsmc_pkg::OP_MSTEP: begin
        if (b[0]) begin
          acc <= acc_next;
        end
        a <= a_next;
        b <= b >> 1;
      end
      rsmc_pkg::OP_WR_RES: begin
        result <= acc;
      end
      rsmc_pkg::OP_WR_BASE: begin
        base <= acc;
        exp  <= exp >> 1;
      end
      default: begin
      end
    endcase
  end

  // The zero test is made at the step that loads the exponent, so it looks
  // at the selected register rather than the exponent register.
  always_comb begin
    stat.cnt_last = (cnt == CNT_W'(1));
    stat.exp_zero = (exp_sel == '0);
    stat.exp_even = ~exp[0];
    stat.b_more   = (b[MOD_WIDTH-1:1] != '0);
    stat.exp_more = (exp[MOD_WIDTH-1:1] != '0);
  end

  assign power = result;

endmodule

[rtl/core/rsa_symbol_modexp_cipher.sv]
// ============================================================================
// rsa_symbol_modexp_cipher - offset symbol modular exponentiation
// Microcoded square-and-multiply over a shift-and-add modular multiplier.
// ============================================================================
// Sequence: an accept step, the reduction steps and the exponent load, then
//   per exponent bit a multiply (odd bits only), a square and their
//   write-backs, and last the emit and return steps.
// Throughput: one item at a time; the shift-and-add multiply loop, one
//   multiplier bit per cycle, sets the rate. The output register lets the
//   next item start while a result still waits for its transfer.
// Reset (synchronous, active high) returns the sequencer to its wait step,
//   empties the output register and loads modulus 77 and exponents 7 and 43.
// ============================================================================
module rsa_symbol_modexp_cipher #(
  parameter int MOD_WIDTH = rsmc_pkg::MOD_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // Input stream.
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [31:0]          s_tdata,   // [31:0] symbol_value
  input  logic                 s_tuser,   // [0] func (0 encrypt, 1 decrypt)
  // Output stream.
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [31:0]          m_tdata,   // [31:0] coded_value
  // Configuration write channel.
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [MOD_WIDTH-1:0] cfg_data
);

  localparam int SUM_W = (MOD_WIDTH > 32) ? MOD_WIDTH : 32;

  rsmc_pkg::pc_t   pc;
  rsmc_pkg::pc_t   pc_next;
  rsmc_pkg::ctrl_t ctrl;
  rsmc_pkg::stat_t stat;

  logic [MOD_WIDTH-1:0] modulus;
  logic [MOD_WIDTH-1:0] public_exponent;
  logic [MOD_WIDTH-1:0] private_exponent;
  logic [MOD_WIDTH-1:0] power;

  logic             in_fire;
  logic             out_busy;
  logic             emit;
  logic             mod_small;
  logic             take_jump;
  logic [SUM_W-1:0] coded_sum;

  // Configuration registers. Writes always complete; an index past the
  // last register is dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus          <= MOD_WIDTH'(rsmc_pkg::MODULUS_RST);
      public_exponent  <= MOD_WIDTH'(rsmc_pkg::PUB_EXP_RST);
      private_exponent <= MOD_WIDTH'(rsmc_pkg::PRIV_EXP_RST);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rsmc_pkg::REG_MODULUS:  modulus          <= cfg_data;
        rsmc_pkg::REG_PUB_EXP:  public_exponent  <= cfg_data;
        rsmc_pkg::REG_PRIV_EXP: private_exponent <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // The sequencer waits at the first step of the program for a transfer
  // on the input side; the datapath captures the item in that cycle.
  assign s_tready = (pc == rsmc_pkg::PC_WAIT);
  assign in_fire  = s_tvalid && s_tready;
  assign out_busy = m_tvalid && !m_tready;

  assign ctrl = rsmc_pkg::ucode(pc);

  always_comb begin
    case (ctrl.cond)
      rsmc_pkg::C_NONE:     take_jump = 1'b0;
      rsmc_pkg::C_ALWAYS:   take_jump = 1'b1;
      rsmc_pkg::C_NO_INPUT: take_jump = !in_fire;
      rsmc_pkg::C_CNT_MORE: take_jump = !stat.cnt_last;
      rsmc_pkg::C_EXP_ZERO: take_jump = stat.exp_zero;
      rsmc_pkg::C_EXP_EVEN: take_jump = stat.exp_even;
      rsmc_pkg::C_B_MORE:   take_jump = stat.b_more;
      rsmc_pkg::C_EXP_MORE: take_jump = stat.exp_more;
      rsmc_pkg::C_OUT_BUSY: take_jump = out_busy;
      default:              take_jump = 1'b1;
    endcase
    pc_next = take_jump ? ctrl.target : pc + rsmc_pkg::pc_t'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= rsmc_pkg::PC_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

  rsmc_datapath #(
    .MOD_WIDTH(MOD_WIDTH)
  ) u_datapath (
    .clk              (clk),
    .load             (in_fire),
    .load_func        (s_tuser),
    .load_symbol      (s_tdata),
    .ctrl             (ctrl),
    .modulus          (modulus),
    .public_exponent  (public_exponent),
    .private_exponent (private_exponent),
    .stat             (stat),
    .power            (power)
  );

  // A modulus below two makes the power zero, whatever the loop computed.
  assign mod_small = (modulus < MOD_WIDTH'(2));
  assign emit      = (ctrl.op == rsmc_pkg::OP_EMIT) && !out_busy;
  assign coded_sum = (mod_small ? '0 : SUM_W'(power)) + SUM_W'(rsmc_pkg::SYMBOL_OFFSET);

  // Output register: loaded when the emit step finds it free, emptied by
  // a transfer on the output side.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= coded_sum[31:0];
    end
  end

  // The step counter never leaves the program.
  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    pc <= rsmc_pkg::PC_LAST)
    else $error("step counter outside the program");

  // An emit step that finds the output register free fills it.
  a_emit_fills: assert property (@(posedge clk) disable iff (rst)
    emit |=> m_tvalid)
    else $error("emit step did not fill the output register");

  // With a degenerate modulus the result is the bare offset.
  a_small_mod: assert property (@(posedge clk) disable iff (rst)
    (emit && mod_small) |=> (m_tdata == 32'(rsmc_pkg::SYMBOL_OFFSET)))
    else $error("degenerate modulus gave a result other than the offset");

endmodule

[test/rsa_symbol_modexp_cipher_tb.sv]
`timescale 1ns / 100ps
// ============================================================================
// rsa_symbol_modexp_cipher_tb - self-checking bench for the symbol cipher
// Streams symbols through encrypt and decrypt under a series of key settings
// and checks every coded value against a square-and-multiply predictor.
// ============================================================================
module rsa_symbol_modexp_cipher_tb;

  localparam int MOD_W = rsmc_pkg::MOD_WIDTH_DEF;

  // Operation selector carried on s_tuser.
  localparam logic FUNC_ENCRYPT = 1'b0;
  localparam logic FUNC_DECRYPT = 1'b1;

  // The index the block has no register behind; writes to it must be dropped.
  localparam logic [1:0] REG_UNUSED = 2'd3;

  localparam logic [MOD_W-1:0] MOD_ALL_ONES = {MOD_W{1'b1}};
  localparam logic [31:0] OFFSET32 = 32'(rsmc_pkg::SYMBOL_OFFSET);
  localparam logic [63:0] OFFSET64 = 64'(rsmc_pkg::SYMBOL_OFFSET);

  // The limit leaves room for every item being as slow as a full-width
  // exponent makes it, plus every stall.
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int DRAIN_CYCLES = 2500;
  localparam int TOTAL_ITEMS = 290;
  localparam int LONG_HOLD_CYCLES = 4000;
  localparam int LONG_HOLD_AFTER = 60;

  typedef struct packed {
    logic        func;
    logic [31:0] symbol;
  } symbol_item_t;

  typedef enum int {KEY_PAIR, NARROW_KEYS, WIDE_KEYS, MEDIUM_KEYS} key_kind_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [31:0]          s_tdata = '0;   // [31:0] symbol_value
  logic                 s_tuser = 1'b0; // [0] func (0 encrypt, 1 decrypt)
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [31:0]          m_tdata;        // [31:0] coded_value
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [1:0]           cfg_index = '0;
  logic [MOD_W-1:0]     cfg_data = '0;

  // Shadow copy of the key registers, starting from their reset values.
  logic [MOD_W-1:0] modulus_q = MOD_W'(rsmc_pkg::MODULUS_RST);
  logic [MOD_W-1:0] public_exp_q = MOD_W'(rsmc_pkg::PUB_EXP_RST);
  logic [MOD_W-1:0] private_exp_q = MOD_W'(rsmc_pkg::PRIV_EXP_RST);

  symbol_item_t pending_items[$];
  logic [31:0]  expected_codes[$];

  // Items taken from the pending queue whose coded value has not come back.
  int owed_results = 0;
  int queued_total = 0;
  int results_seen = 0;
  int errors = 0;
  int cycle_count = 0;

  int tx_gap = 0;
  int tx_quiet = 0;
  int rx_wait = 0;
  int rx_quiet = 0;
  bit long_hold_done = 1'b0;

  rsa_symbol_modexp_cipher #(
    .MOD_WIDTH(MOD_W)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // Coded value of one symbol under the current keys. The offset symbol is
  // taken as a 64-bit unsigned difference, so codes below the offset wrap to
  // just under 2^64 before the reduction. All operands stay below 2^31, so a
  // 64-bit product never overflows. A modulus below two gives a zero power.
  function automatic logic [31:0] cipher_value(logic func, logic [31:0] symbol);
    logic [63:0] m;
    logic [63:0] base;
    logic [63:0] expo;
    logic [63:0] acc;
    m = 64'(modulus_q);
    expo = (func == FUNC_DECRYPT) ? 64'(private_exp_q) : 64'(public_exp_q);
    if (m < 64'd2) begin
      return OFFSET32;
    end
    base = ({32'd0, symbol} - OFFSET64) % m;
    acc = 64'd1;
    while (expo != 64'd0) begin
      if (expo[0]) begin
        acc = (acc * base) % m;
      end
      base = (base * base) % m;
      expo = expo >> 1;
    end
    return acc[31:0] + OFFSET32;
  endfunction

  // Symbol mix: any 32-bit code, codes below the offset, lowercase letters,
  // ciphertext-like codes just above the offset, and codes near the top.
  function automatic logic [31:0] random_symbol(logic [MOD_W-1:0] m);
    logic [31:0] v;
    case ($urandom_range(0, 4))
      0: v = $urandom;
      1: v = $urandom_range(0, 95);
      2: v = OFFSET32 + $urandom_range(0, 31);
      3: v = OFFSET32 + $urandom_range(0, m - 1);
      default: v = 32'hFFFF_FF00 | $urandom_range(0, 255);
    endcase
    return v;
  endfunction

  // Idle cycles before the next item: mostly drawn at random, with the occasional
  // run of twenty items that see no idling at all.
  function automatic int idle_draw(inout int quiet);
    int n;
    if (quiet > 0) begin
      quiet--;
      n = 0;
    end else begin
      n = $urandom_range(0, 6);
      if ($urandom_range(0, 24) == 0) begin
        quiet = 20;
      end
    end
    return n;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offers pending items on the input stream. The coded value is
  // predicted at the edge where the transfer happens, so it sees the keys
  // that the block holds at that moment.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : symbol_driver
    symbol_item_t item;
    logic offer;
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_gap = 0;
    end else begin
      offer = s_tvalid;
      if (s_tvalid && s_tready) begin
        expected_codes.push_back(cipher_value(s_tuser, s_tdata));
        offer = 1'b0;
        tx_gap = idle_draw(tx_quiet);
      end
      if (!offer) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (pending_items.size() != 0) begin
          item = pending_items.pop_front();
          owed_results++;
          s_tdata <= item.symbol;
          s_tuser <= item.func;
          offer = 1'b1;
        end
      end
      // Valid changes at most once per edge, so a back-to-back item keeps it high.
      s_tvalid <= offer;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: takes coded values off the output stream and compares each with
  // the oldest prediction. Once, while the sender still has a backlog, it
  // holds ready low long enough for the block to fill up and stall its input.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : code_monitor
    logic [31:0] want;
    if (rst) begin
      m_tready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (expected_codes.size() == 0) begin
          $error("coded_value with nothing expected: expected none, actual %0d", m_tdata);
          errors++;
        end else begin
          want = expected_codes.pop_front();
          owed_results--;
          if (m_tdata !== want) begin
            $error("coded_value mismatch: expected %0d, actual %0d", want, m_tdata);
            errors++;
          end
        end
        if (!long_hold_done && results_seen >= LONG_HOLD_AFTER &&
            pending_items.size() > 4) begin
          rx_wait = LONG_HOLD_CYCLES;
          long_hold_done = 1'b1;
        end else begin
          rx_wait = idle_draw(rx_quiet);
        end
      end
      if (rx_wait > 0) begin
        rx_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog: a hung block or a lost result ends the run here.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic queue_item(input logic func, input logic [31:0] symbol);
    symbol_item_t item;
    item.func = func;
    item.symbol = symbol;
    pending_items.push_back(item);
    queued_total++;
  endtask

  // Waits until every queued item has been sent and its result has arrived.
  // The driver moves an item from the queue to the owed count in one step,
  // so the two together never both read as empty while one is in flight.
  task automatic wait_idle();
    while (pending_items.size() != 0 || owed_results != 0) begin
      @(posedge clk);
    end
  endtask

  // One register transfer. Valid is left high so that a following write goes
  // out on the next edge; the caller lowers it after the last one.
  task automatic write_reg(input logic [1:0] index, input logic [MOD_W-1:0] value);
    cfg_index <= index;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    case (index)
      rsmc_pkg::REG_MODULUS:  modulus_q = value;
      rsmc_pkg::REG_PUB_EXP:  public_exp_q = value;
      rsmc_pkg::REG_PRIV_EXP: private_exp_q = value;
      default: ;
    endcase
  endtask

  task automatic write_keys(input logic [MOD_W-1:0] n, input logic [MOD_W-1:0] e,
                            input logic [MOD_W-1:0] d);
    write_reg(rsmc_pkg::REG_MODULUS, n);
    write_reg(rsmc_pkg::REG_PUB_EXP, e);
    write_reg(rsmc_pkg::REG_PRIV_EXP, d);
    cfg_valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus. Every phase fills the pending queue in one go and then drains
  // completely, which is also where the sender pauses until all results are
  // in. Keys are only rewritten while the block is drained.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    key_kind_t kind;
    logic [MOD_W-1:0] n;
    logic [MOD_W-1:0] e;
    logic [MOD_W-1:0] d;
    logic [31:0] plain;
    int target;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset keys (77, 7, 43) with no write at all: symbols on both sides of
    // the offset, the offset itself, the modulus edge and the code extremes.
    queue_item(FUNC_ENCRYPT, 32'd0);
    queue_item(FUNC_DECRYPT, 32'd0);
    queue_item(FUNC_ENCRYPT, 32'd95);
    queue_item(FUNC_DECRYPT, 32'd96);
    queue_item(FUNC_ENCRYPT, 32'd97);
    queue_item(FUNC_ENCRYPT, 32'd127);
    queue_item(FUNC_DECRYPT, OFFSET32 + 32'd76);
    queue_item(FUNC_ENCRYPT, OFFSET32 + 32'd77);
    queue_item(FUNC_DECRYPT, 32'hFFFF_FFFF);
    queue_item(FUNC_ENCRYPT, 32'h8000_0000);
    queue_item(FUNC_DECRYPT, 32'h5555_5555);
    queue_item(FUNC_ENCRYPT, 32'hAAAA_AAAA);
    wait_idle();

    // Largest modulus and full-width exponents: the slowest items there are.
    write_keys(MOD_ALL_ONES, MOD_ALL_ONES, MOD_ALL_ONES);
    queue_item(FUNC_ENCRYPT, 32'd0);
    queue_item(FUNC_DECRYPT, 32'hFFFF_FFFF);
    queue_item(FUNC_ENCRYPT, 32'h7FFF_FFFF);
    wait_idle();

    // Smallest legal modulus with unit exponents.
    write_keys(2, 1, 1);
    queue_item(FUNC_ENCRYPT, 32'd97);
    queue_item(FUNC_DECRYPT, 32'd96);
    queue_item(FUNC_ENCRYPT, 32'd95);
    wait_idle();

    // Modulus of zero with zero exponents: the power collapses to zero.
    write_keys('0, '0, '0);
    queue_item(FUNC_ENCRYPT, 32'd200);
    queue_item(FUNC_DECRYPT, 32'd5);
    wait_idle();

    // Modulus of one, then a real modulus with zero exponents, where the
    // power is one. The write to the unused index must change nothing.
    write_keys(1, '0, '0);
    queue_item(FUNC_ENCRYPT, 32'd200);
    wait_idle();
    write_reg(rsmc_pkg::REG_MODULUS, 77);
    write_reg(REG_UNUSED, MOD_ALL_ONES);
    cfg_valid <= 1'b0;
    queue_item(FUNC_ENCRYPT, 32'd100);
    queue_item(FUNC_DECRYPT, 32'd3);
    wait_idle();

    // Random phases, each under its own keys. Genuine key pairs also get
    // round trips: a plaintext and then the ciphertext it was predicted to
    // encrypt to, which must decrypt back to the plaintext.
    while (queued_total < TOTAL_ITEMS) begin
      kind = key_kind_t'($urandom_range(0, 3));
      case (kind)
        KEY_PAIR: begin
          case ($urandom_range(0, 2))
            0: begin n = 77; e = 7; d = 43; end
            1: begin n = 3233; e = 17; d = 2753; end
            default: begin n = 143; e = 7; d = 103; end
          endcase
        end
        NARROW_KEYS: begin
          n = MOD_W'($urandom_range(2, 65535));
          e = MOD_W'($urandom_range(1, 255));
          d = MOD_W'($urandom_range(1, 255));
        end
        WIDE_KEYS: begin
          n = MOD_W'($urandom_range(2, MOD_ALL_ONES));
          e = MOD_W'($urandom_range(1, MOD_ALL_ONES));
          d = MOD_W'($urandom_range(1, MOD_ALL_ONES));
        end
        default: begin
          n = MOD_W'($urandom_range(2, 1 << 20));
          e = MOD_W'($urandom_range(1, 4095));
          d = MOD_W'($urandom_range(1, 4095));
        end
      endcase
      write_reg(rsmc_pkg::REG_MODULUS, n);
      write_reg(rsmc_pkg::REG_PUB_EXP, e);
      write_reg(rsmc_pkg::REG_PRIV_EXP, d);
      if ($urandom_range(0, 3) == 0) begin
        write_reg(REG_UNUSED, MOD_W'($urandom));
      end
      cfg_valid <= 1'b0;

      // Wide keys make every item slow, so those phases stay short.
      target = queued_total + ((kind == WIDE_KEYS) ? 6 : $urandom_range(28, 40));
      while (queued_total < target) begin
        if (kind == KEY_PAIR && $urandom_range(0, 1) == 1) begin
          plain = OFFSET32 + $urandom_range(0, n - 1);
          queue_item(FUNC_ENCRYPT, plain);
          queue_item(FUNC_DECRYPT, cipher_value(FUNC_ENCRYPT, plain));
        end else begin
          queue_item(1'($urandom_range(0, 1)), random_symbol(n));
        end
      end
      wait_idle();
    end

    // Everything has come back; give a stray extra result time to show up.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_codes.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/rsmc_pkg.sv
rtl/core/rsmc_datapath.sv
rtl/core/rsa_symbol_modexp_cipher.sv
test/rsa_symbol_modexp_cipher_tb.sv
